@@ hdl/asm_pkg.sv @@
// shared types and constants of the active segment matcher
package asm_pkg;

   // field widths fixed by the request and response formats
   localparam int unsigned TICK_W   = 48;
   localparam int unsigned POS_W    = 49;
   localparam int unsigned KIND_W   = 4;
   localparam int unsigned MARGIN_W = 32;

   // margin after reset: half a second in 100 ns ticks
   localparam logic [MARGIN_W-1:0] MARGIN_RESET = 32'd5000000;

   // request commands
   typedef enum logic [1:0] {
      CMD_CLEAR    = 2'd0,
      CMD_APPEND   = 2'd1,
      CMD_POSITION = 2'd2,
      CMD_RESERVED = 2'd3
   } cmd_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // one stored segment
   typedef struct packed {
      logic [TICK_W-1:0] seg_start;
      logic [TICK_W-1:0] seg_end;
      logic [KIND_W-1:0] seg_kind;
   } seg_entry_type;

endpackage

@@ hdl/asm_if.sv @@
// request and response channel interfaces of the active segment matcher
interface asm_req_if;
   logic                              valid;
   logic                              ready;
   logic [1:0]                        cmd;
   logic signed [asm_pkg::POS_W-1:0]  position_ticks;
   logic                              position_valid;
   logic [asm_pkg::TICK_W-1:0]        segment_start;
   logic [asm_pkg::TICK_W-1:0]        segment_end;
   logic [asm_pkg::KIND_W-1:0]        segment_kind;

   modport source (output valid, output cmd, output position_ticks, output position_valid,
                   output segment_start, output segment_end, output segment_kind,
                   input ready);
   modport sink (input valid, input cmd, input position_ticks, input position_valid,
                 input segment_start, input segment_end, input segment_kind,
                 output ready);
endinterface

interface asm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [asm_pkg::KIND_W-1:0]    active_kind;
   logic [asm_pkg::TICK_W-1:0]    active_end_ticks;

   modport source (output valid, output active_kind, output active_end_ticks, input ready);
   modport sink (input valid, input active_kind, input active_end_ticks, output ready);
endinterface

@@ hdl/active_segment_matcher_unit.sv @@
// active segment matcher top level: segment memory, scan controller, response register
//
// Segments live in one synchronous memory of MAX_SEGMENTS entries (start, end, kind)
// with a registered read. Clear and append requests are handled in the idle state; an
// append to a full table is dropped. A position update with a valid position walks the
// memory in append order, one entry read per cycle with the compare of the previous
// entry overlapped, and stops at the first segment with start <= pos < end - margin;
// an invalid position or an empty table skips the walk. A response is produced only
// when the matched (kind, end) pair differs from the active one; it sits in an output
// register, so the next request is taken while it waits, and a later update only holds
// in its finish state if the register is still occupied. The user must write the margin
// register through csr_wr_en / csr_wr_data only while the block is idle; the block
// itself does not enforce this.
module active_segment_matcher_unit #(
   parameter int unsigned MAX_SEGMENTS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   asm_req_if.sink                            req_chan,
   asm_rsp_if.source                          rsp_chan,
   input  logic                               csr_wr_en,
   input  logic [asm_pkg::MARGIN_W-1:0]       csr_wr_data
);

   localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
   localparam int unsigned AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int unsigned CMP_W = asm_pkg::POS_W + 1;

   // segment memory
   asm_pkg::seg_entry_type seg_mem [MAX_SEGMENTS];
   asm_pkg::seg_entry_type rd_data_ff;

   // control and datapath registers
   asm_pkg::state_type                   state_ff, state_in;
   logic [CW-1:0]                        count_ff, count_in;
   logic [CW-1:0]                        idx_ff, idx_in;
   logic                                 pend_ff, pend_in;
   logic signed [asm_pkg::POS_W-1:0]     pos_ff, pos_in;
   logic [asm_pkg::KIND_W-1:0]           cand_kind_ff, cand_kind_in;
   logic [asm_pkg::TICK_W-1:0]           cand_end_ff, cand_end_in;
   logic [asm_pkg::KIND_W-1:0]           cur_kind_ff, cur_kind_in;
   logic [asm_pkg::TICK_W-1:0]           cur_end_ff, cur_end_in;
   logic [asm_pkg::MARGIN_W-1:0]         margin_ff;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [asm_pkg::KIND_W-1:0]           rsp_kind_ff, rsp_kind_in;
   logic [asm_pkg::TICK_W-1:0]           rsp_end_ff, rsp_end_in;

   logic                                 mem_we;
   logic                                 issue;
   logic                                 match_now;
   logic signed [CMP_W-1:0]              pos_ext;
   logic signed [CMP_W-1:0]              start_ext;
   logic signed [CMP_W-1:0]              limit_ext;

   // window compare on the entry just read
   always_comb begin
      pos_ext   = CMP_W'(pos_ff);
      start_ext = signed'({2'b00, rd_data_ff.seg_start});
      limit_ext = signed'({2'b00, rd_data_ff.seg_end})
                  - signed'({{(CMP_W - asm_pkg::MARGIN_W){1'b0}}, margin_ff});
      match_now = pend_ff && (pos_ext >= start_ext) && (pos_ext < limit_ext);
   end

   // next state and outputs
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      pend_in      = 1'b0;
      pos_in       = pos_ff;
      cand_kind_in = cand_kind_ff;
      cand_end_in  = cand_end_ff;
      cur_kind_in  = cur_kind_ff;
      cur_end_in   = cur_end_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_end_in   = rsp_end_ff;
      req_chan.ready = 1'b0;
      mem_we       = 1'b0;
      issue        = 1'b0;

      case (state_ff)
         asm_pkg::ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               case (req_chan.cmd)
                  asm_pkg::CMD_CLEAR: begin
                     count_in    = '0;
                     cur_kind_in = '0;
                     cur_end_in  = '0;
                  end
                  asm_pkg::CMD_APPEND: begin
                     if (count_ff < CW'(MAX_SEGMENTS)) begin
                        mem_we   = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  asm_pkg::CMD_POSITION: begin
                     pos_in       = req_chan.position_ticks;
                     cand_kind_in = '0;
                     cand_end_in  = '0;
                     idx_in       = '0;
                     if (req_chan.position_valid && (count_ff != '0)) begin
                        state_in = asm_pkg::ST_SCAN;
                     end else begin
                        state_in = asm_pkg::ST_FINISH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         asm_pkg::ST_SCAN: begin
            // read the next entry while the previous one is compared
            issue   = (idx_ff < count_ff) && !match_now;
            pend_in = issue;
            if (issue) begin
               idx_in = idx_ff + CW'(1);
            end
            if (match_now) begin
               cand_kind_in = rd_data_ff.seg_kind;
               cand_end_in  = rd_data_ff.seg_end;
               state_in     = asm_pkg::ST_FINISH;
            end else if (!issue) begin
               state_in = asm_pkg::ST_FINISH;
            end
         end

         asm_pkg::ST_FINISH: begin
            // report only a change of the active pair
            if ((cand_kind_ff != cur_kind_ff) || (cand_end_ff != cur_end_ff)) begin
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = cand_kind_ff;
                  rsp_end_in   = cand_end_ff;
                  cur_kind_in  = cand_kind_ff;
                  cur_end_in   = cand_end_ff;
                  state_in     = asm_pkg::ST_IDLE;
               end
            end else begin
               state_in = asm_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = asm_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= asm_pkg::ST_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         cur_kind_ff  <= '0;
         cur_end_ff   <= '0;
         margin_ff    <= asm_pkg::MARGIN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         cur_kind_ff  <= cur_kind_in;
         cur_end_ff   <= cur_end_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            margin_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      cand_kind_ff <= cand_kind_in;
      cand_end_ff  <= cand_end_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_end_ff   <= rsp_end_in;
   end

   // segment memory write port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         seg_mem[count_ff[AW-1:0]] <= '{seg_start: req_chan.segment_start,
                                        seg_end:   req_chan.segment_end,
                                        seg_kind:  req_chan.segment_kind};
      end
   end

   // segment memory read port
   always_ff @(posedge clock) begin
      if (issue) begin
         rd_data_ff <= seg_mem[idx_ff[AW-1:0]];
      end
   end

   // response channel
   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.active_kind      = rsp_kind_ff;
   assign rsp_chan.active_end_ticks = rsp_end_ff;

endmodule

@@ bench/active_segment_matcher_unit_tb.sv @@
// self-checking testbench for the active segment matcher: scoreboard, stimulus and stall drivers
module active_segment_matcher_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned MAX_SEG     = 16;
   localparam int unsigned SETTLE_CYC  = 2 * MAX_SEG + 8;
   localparam int unsigned LONG_HOLD   = 400;
   localparam int unsigned CYCLE_LIMIT = 600000;
   localparam int unsigned PHASE_ITEMS = 230;

   // one request as seen on the input channel
   typedef struct {
      asm_pkg::cmd_type                  cmd;
      logic signed [asm_pkg::POS_W-1:0]  pos;
      logic                              pos_ok;
      logic [asm_pkg::TICK_W-1:0]        s_start;
      logic [asm_pkg::TICK_W-1:0]        s_stop;
      logic [asm_pkg::KIND_W-1:0]        s_kind;
   } request_type;

   // the active (kind, end) pair announced on the response channel
   typedef struct {
      logic [asm_pkg::KIND_W-1:0] kind;
      logic [asm_pkg::TICK_W-1:0] stop_ticks;
   } active_pair_type;

   // segment table mirror and queue of announced active-pair changes
   class segment_scoreboard;
      logic [asm_pkg::TICK_W-1:0]   tbl_start [MAX_SEG];
      logic [asm_pkg::TICK_W-1:0]   tbl_stop  [MAX_SEG];
      logic [asm_pkg::KIND_W-1:0]   tbl_kind  [MAX_SEG];
      int unsigned                  fill;
      logic [asm_pkg::KIND_W-1:0]   cur_kind;
      logic [asm_pkg::TICK_W-1:0]   cur_stop;
      logic [asm_pkg::MARGIN_W-1:0] margin;
      active_pair_type              change_q[$];
      int unsigned                  mismatches;
      int unsigned                  requests_seen;
      int unsigned                  changes_seen;
      int unsigned                  dropped_appends;

      function new();
         fill            = 0;
         cur_kind        = '0;
         cur_stop        = '0;
         margin          = asm_pkg::MARGIN_RESET;
         mismatches      = 0;
         requests_seen   = 0;
         changes_seen    = 0;
         dropped_appends = 0;
      endfunction

      function int pending();
         return change_q.size();
      endfunction

      function void report_fail(string what);
         mismatches++;
         if (mismatches <= 10) begin
            $display("[%0t] error: %s", $realtime, what);
         end
      endfunction

      // update the mirror and predict the active-pair change a request causes
      function void note_request(request_type r);
         longint                     pos_v;
         longint                     lo;
         longint                     lim;
         logic [asm_pkg::KIND_W-1:0] cand_kind;
         logic [asm_pkg::TICK_W-1:0] cand_stop;
         active_pair_type            pair;
         requests_seen++;
         case (r.cmd)
            asm_pkg::CMD_CLEAR: begin
               fill     = 0;
               cur_kind = '0;
               cur_stop = '0;
            end
            asm_pkg::CMD_APPEND: begin
               if (fill < MAX_SEG) begin
                  tbl_start[fill] = r.s_start;
                  tbl_stop[fill]  = r.s_stop;
                  tbl_kind[fill]  = r.s_kind;
                  fill++;
               end else begin
                  dropped_appends++;
               end
            end
            asm_pkg::CMD_POSITION: begin
               cand_kind = '0;
               cand_stop = '0;
               if (r.pos_ok) begin
                  pos_v = longint'(r.pos);
                  // first segment in append order with start <= pos < end - margin
                  for (int i = 0; i < fill; i++) begin
                     lo  = longint'({16'd0, tbl_start[i]});
                     lim = longint'({16'd0, tbl_stop[i]}) - longint'({32'd0, margin});
                     if (pos_v >= lo && pos_v < lim) begin
                        cand_kind = tbl_kind[i];
                        cand_stop = tbl_stop[i];
                        break;
                     end
                  end
               end
               if (cand_kind !== cur_kind || cand_stop !== cur_stop) begin
                  cur_kind        = cand_kind;
                  cur_stop        = cand_stop;
                  pair.kind       = cand_kind;
                  pair.stop_ticks = cand_stop;
                  change_q.push_back(pair);
               end
            end
            default: begin
            end
         endcase
      endfunction

      // compare one response against the oldest predicted change
      function void check_response(logic [asm_pkg::KIND_W-1:0] kind,
                                   logic [asm_pkg::TICK_W-1:0] stop_ticks);
         active_pair_type want;
         changes_seen++;
         if (change_q.size() == 0) begin
            report_fail($sformatf("unexpected response kind %0d end %0d", kind, stop_ticks));
         end else begin
            want = change_q.pop_front();
            if (kind !== want.kind || stop_ticks !== want.stop_ticks) begin
               report_fail($sformatf("response kind %0d end %0d, expected kind %0d end %0d",
                                     kind, stop_ticks, want.kind, want.stop_ticks));
            end
         end
      endfunction
   endclass

   logic                         clock;
   logic                         reset;
   logic                         csr_wr_en;
   logic [asm_pkg::MARGIN_W-1:0] csr_wr_data;

   asm_req_if req_chan ();
   asm_rsp_if rsp_chan ();

   segment_scoreboard board = new();

   int unsigned items_sent  = 0;
   int          burst_left  = 0;
   int unsigned cycle_count = 0;
   bit          hold_armed  = 1'b0;

   active_segment_matcher_unit #(
      .MAX_SEGMENTS (MAX_SEG)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan.sink),
      .rsp_chan    (rsp_chan.source),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // 10 ns clock
   initial begin
      clock = 1'b0;
      forever begin
         #5 clock = ~clock;
      end
   end

   // run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d changes still awaited", cycle_count,
               board.pending());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // watch both channels; responses first since they belong to older requests
   always @(posedge clock) begin : channel_monitor
      request_type seen;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            board.check_response(rsp_chan.active_kind, rsp_chan.active_end_ticks);
         end
         if (req_chan.valid && req_chan.ready) begin
            seen.cmd     = asm_pkg::cmd_type'(req_chan.cmd);
            seen.pos     = req_chan.position_ticks;
            seen.pos_ok  = req_chan.position_valid;
            seen.s_start = req_chan.segment_start;
            seen.s_stop  = req_chan.segment_end;
            seen.s_kind  = req_chan.segment_kind;
            board.note_request(seen);
         end
      end
   end

   // response ready: changing stall patterns plus one long hold-off on request
   initial begin : response_stall
      int mode;
      int mode_left;
      int hold_left;
      mode      = 0;
      mode_left = 0;
      hold_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_armed) begin
            hold_armed = 1'b0;
            hold_left  = LONG_HOLD;
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            case (mode)
               0:       rsp_chan.ready <= 1'b1;
               1:       rsp_chan.ready <= 1'($urandom_range(0, 1));
               2:       rsp_chan.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_chan.ready <= (mode_left % 4 == 0);
            endcase
         end
      end
   end

   function automatic logic [asm_pkg::TICK_W-1:0] rand_ticks();
      logic [63:0] t;
      t = {$urandom(), $urandom()};
      return t[asm_pkg::TICK_W-1:0];
   endfunction

   // request with every field scrambled; callers overwrite what the command uses
   function automatic request_type scrambled(asm_pkg::cmd_type c);
      request_type r;
      logic [63:0] t;
      t         = {$urandom(), $urandom()};
      r.cmd     = c;
      r.pos     = t[asm_pkg::POS_W-1:0];
      r.pos_ok  = 1'($urandom_range(0, 1));
      r.s_start = rand_ticks();
      r.s_stop  = rand_ticks();
      r.s_kind  = asm_pkg::KIND_W'($urandom_range(0, 15));
      return r;
   endfunction

   // offer one request in bursts with random gaps, return at its acceptance edge
   task automatic send_request(request_type r);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 10);
      end
      burst_left--;
      req_chan.valid          <= 1'b1;
      req_chan.cmd            <= r.cmd;
      req_chan.position_ticks <= r.pos;
      req_chan.position_valid <= r.pos_ok;
      req_chan.segment_start  <= r.s_start;
      req_chan.segment_end    <= r.s_stop;
      req_chan.segment_kind   <= r.s_kind;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic append_seg(logic [asm_pkg::TICK_W-1:0] s, logic [asm_pkg::TICK_W-1:0] e,
                             logic [asm_pkg::KIND_W-1:0] k);
      request_type r;
      r         = scrambled(asm_pkg::CMD_APPEND);
      r.s_start = s;
      r.s_stop  = e;
      r.s_kind  = k;
      send_request(r);
   endtask

   task automatic move_to(longint p, logic ok);
      request_type r;
      r        = scrambled(asm_pkg::CMD_POSITION);
      r.pos    = p[asm_pkg::POS_W-1:0];
      r.pos_ok = ok;
      send_request(r);
   endtask

   // stop offering, wait for every announced change and for a trailing scan to finish
   task automatic drain_and_settle();
      req_chan.valid <= 1'b0;
      burst_left = 0;
      while (board.pending() > 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic write_margin(logic [asm_pkg::MARGIN_W-1:0] v);
      drain_and_settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      board.margin = v;
   endtask

   // hand-picked corner cases under the reset margin
   task automatic directed_cases();
      longint m;
      m = longint'({32'd0, asm_pkg::MARGIN_RESET});
      move_to(0, 1'b1);                                // empty table
      move_to(-5, 1'b0);                               // invalid position
      append_seg(1000, asm_pkg::TICK_W'(1000 + m + 1), 4'd0); // kind zero, matches at 1000
      append_seg(1000, 20000000, 4'd7);                // overlaps, loses to the earlier one
      append_seg(100, asm_pkg::TICK_W'(100 + m), 4'd3); // end exactly start + margin
      append_seg(48'hFFFF_FFFF_FFFF, 48'h0, 4'd1);     // end below margin
      append_seg(0, 48'hFFFF_FFFF_FFFF, 4'd15);        // spans the whole range
      move_to(1000, 1'b1);
      move_to(1001, 1'b1);
      move_to(1002, 1'b1);                             // same pair, nothing to announce
      move_to(100, 1'b1);
      move_to(-1, 1'b1);
      move_to(-(longint'(1) << 48), 1'b1);             // most negative position
      move_to((longint'(1) << 48) - 1, 1'b1);          // largest position
      move_to(50, 1'b1);
      move_to(50, 1'b0);
      move_to(50, 1'b1);
      send_request(scrambled(asm_pkg::CMD_RESERVED));
      send_request(scrambled(asm_pkg::CMD_CLEAR));     // drops the active pair too
      move_to(50, 1'b1);
      append_seg(20, 30, 4'd9);
      move_to(25, 1'b1);
   endtask

   // one table build followed by positions aimed at its segment boundaries
   task automatic run_scenario();
      int                           n_seg;
      int                           n_pos;
      int                           r;
      int                           j;
      logic [asm_pkg::TICK_W-1:0]   base;
      logic [asm_pkg::TICK_W-1:0]   s;
      logic [asm_pkg::TICK_W-1:0]   e;
      logic [asm_pkg::TICK_W-1:0]   lo_a [24];
      logic [asm_pkg::TICK_W-1:0]   hi_a [24];
      logic [asm_pkg::MARGIN_W-1:0] m;
      longint                       len;
      longint                       lo;
      longint                       lim;
      longint                       p;
      logic [63:0]                  r64;
      request_type                  q;
      m = board.margin;
      if ($urandom_range(0, 3) != 0) begin
         send_request(scrambled(asm_pkg::CMD_CLEAR));
      end
      n_seg = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 8);
      case ($urandom_range(0, 2))
         0:       base = rand_ticks();
         1:       base = $urandom_range(0, 100000);
         default: base = rand_ticks() >> $urandom_range(8, 40);
      endcase
      for (int i = 0; i < n_seg; i++) begin
         r = $urandom_range(0, 9);
         if (r < 8) begin
            s = base + $urandom_range(0, 20000);
         end else if (r == 8) begin
            s = rand_ticks();
         end else begin
            s = $urandom_range(0, 100);
         end
         r = $urandom_range(0, 9);
         if (r == 0) begin
            len = $urandom_range(0, m);
            e   = s + len[asm_pkg::TICK_W-1:0];
         end else if (r == 1) begin
            e = rand_ticks();
         end else begin
            len = longint'({32'd0, m}) + $urandom_range(1, 30000);
            if ($urandom_range(0, 4) == 0) begin
               len = len + $urandom();
            end
            e = s + len[asm_pkg::TICK_W-1:0];
         end
         append_seg(s, e, asm_pkg::KIND_W'($urandom_range(0, 15)));
         lo_a[i] = s;
         hi_a[i] = e;
         if ($urandom_range(0, 19) == 0) begin
            send_request(scrambled(asm_pkg::CMD_RESERVED));
         end
      end
      n_pos = $urandom_range(8, 30);
      for (int i = 0; i < n_pos; i++) begin
         r = $urandom_range(0, 19);
         if (n_seg == 0 || r >= 18) begin
            send_request(scrambled(asm_pkg::CMD_POSITION));
         end else if (r == 17) begin
            q        = scrambled(asm_pkg::CMD_POSITION);
            q.pos_ok = 1'b0;
            send_request(q);
         end else begin
            j   = $urandom_range(0, n_seg - 1);
            lo  = longint'({16'd0, lo_a[j]});
            lim = longint'({16'd0, hi_a[j]}) - longint'({32'd0, m});
            case (r % 6)
               0: p = lo;
               1: p = lim - 1;
               2: p = lim;
               3: p = lo - 1;
               default: begin
                  if (lim > lo) begin
                     r64 = {$urandom(), $urandom()};
                     p   = lo + longint'(r64 % (lim - lo));
                  end else begin
                     p = lo;
                  end
               end
            endcase
            move_to(p, 1'b1);
         end
         if ($urandom_range(0, 29) == 0) begin
            send_request(scrambled(asm_pkg::CMD_RESERVED));
         end
      end
   endtask

   // main sequence: reset, corner cases, then random phases over several margins
   initial begin : stimulus
      logic [asm_pkg::MARGIN_W-1:0] margins [6];
      reset                   <= 1'b1;
      csr_wr_en               <= 1'b0;
      csr_wr_data             <= '0;
      req_chan.valid          <= 1'b0;
      req_chan.cmd            <= asm_pkg::CMD_CLEAR;
      req_chan.position_ticks <= '0;
      req_chan.position_valid <= 1'b0;
      req_chan.segment_start  <= '0;
      req_chan.segment_end    <= '0;
      req_chan.segment_kind   <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      directed_cases();

      margins[0] = asm_pkg::MARGIN_RESET;
      margins[1] = '0;
      margins[2] = '1;
      margins[3] = $urandom_range(1, 1000);
      margins[4] = $urandom();
      margins[5] = asm_pkg::MARGIN_RESET;
      for (int ph = 0; ph < 6; ph++) begin
         if (ph > 0) begin
            write_margin(margins[ph]);
         end else begin
            drain_and_settle();
            hold_armed = 1'b1;
         end
         while (items_sent < PHASE_ITEMS * (ph + 1) + 25) begin
            run_scenario();
         end
      end

      drain_and_settle();
      $display("run covered %0d requests with %0d appends dropped on a full table",
               board.requests_seen, board.dropped_appends);
      $display("%0d active-segment changes checked over six margin settings, %0d errors",
               board.changes_seen, board.mismatches);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
